// File: hw/rtl/assert_macros.svh
// Assertion helpers, included by rgb_pixel_pack_ordered_dither_unit.sv.
// Every check samples on the rising edge of clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_PROP(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

`define ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(lbl, prop, msg)

`define ASSERT_NEVER(lbl, expr, msg)

`endif

`endif

// File: hw/rtl/rppd_pkg.sv
`default_nettype none

package rppd_pkg;

	// Field widths
	localparam int unsigned COORD_W  = 12;
	localparam int unsigned COMP_W   = 8;
	localparam int unsigned WORD_W   = 32;
	localparam int unsigned SHIFT_W  = 5;
	localparam int unsigned LEVEL_W  = 3;
	localparam int unsigned THR_W    = 5;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned IN_DATA_W = 48;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_COLOR_MODE = 2'd0,
		CFG_RED_MASK   = 2'd1,
		CFG_GREEN_MASK = 2'd2,
		CFG_BLUE_MASK  = 2'd3
	} cfg_idx_t;

	// Colour modes
	localparam logic MODE_TRUECOLOR = 1'b0;
	localparam logic MODE_PSEUDO    = 1'b1;

	// Register reset values
	localparam logic [WORD_W-1:0] RED_MASK_RST   = 32'h00FF_0000;
	localparam logic [WORD_W-1:0] GREEN_MASK_RST = 32'h0000_FF00;
	localparam logic [WORD_W-1:0] BLUE_MASK_RST  = 32'h0000_00FF;

	// Top quantised level for three-bit and two-bit components
	localparam logic [LEVEL_W-1:0] TOP_LEVEL_3B = 3'd7;
	localparam logic [LEVEL_W-1:0] TOP_LEVEL_2B = 3'd3;

	// Round-up flags passed from stage 1 to the dither units
	typedef struct packed {
		logic red;
		logic green;
		logic blue;
	} round_up_t;

	// 4x4 Bayer threshold for the three-bit scale
	function automatic logic [THR_W-1:0] bayer_thr(input logic [1:0] row,
		input logic [1:0] col);
		logic [THR_W-1:0] t;
		begin
			case ({row, col})
				4'h0: t = 5'd0;
				4'h1: t = 5'd24;
				4'h2: t = 5'd6;
				4'h3: t = 5'd30;
				4'h4: t = 5'd16;
				4'h5: t = 5'd8;
				4'h6: t = 5'd22;
				4'h7: t = 5'd14;
				4'h8: t = 5'd4;
				4'h9: t = 5'd28;
				4'hA: t = 5'd2;
				4'hB: t = 5'd26;
				4'hC: t = 5'd20;
				4'hD: t = 5'd12;
				4'hE: t = 5'd18;
				4'hF: t = 5'd10;
				default: t = 5'd0;
			endcase
			return t;
		end
	endfunction

	// Leading zero count of a 32-bit mask, binary search in five steps.
	// An all-zero mask gives 31; the mask itself clears that channel later.
	function automatic logic [SHIFT_W-1:0] lead_zeros(input logic [WORD_W-1:0] m);
		logic [WORD_W-1:0] v;
		logic [SHIFT_W-1:0] n;
		begin
			v = m;
			n = '0;
			if (v[31:16] == 16'h0) begin
				n[4] = 1'b1;
				v = {v[15:0], 16'h0};
			end
			if (v[31:24] == 8'h0) begin
				n[3] = 1'b1;
				v = {v[23:0], 8'h0};
			end
			if (v[31:28] == 4'h0) begin
				n[2] = 1'b1;
				v = {v[27:0], 4'h0};
			end
			if (v[31:30] == 2'h0) begin
				n[1] = 1'b1;
				v = {v[29:0], 2'h0};
			end
			if (!v[31]) begin
				n[0] = 1'b1;
			end
			return n;
		end
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/rppd_align.sv
`default_nettype none

module rppd_align (
	input  wire logic [rppd_pkg::COMP_W-1:0]  comp,
	input  wire logic [rppd_pkg::SHIFT_W-1:0] lz,
	output logic      [rppd_pkg::WORD_W-1:0]  aligned
);
	import rppd_pkg::*;

	logic [WORD_W-1:0] top_aligned;

	// Park the component at the top of the word, then drop it so its
	// top bit lands on the mask's top bit; low bits fall off the end
	assign top_aligned = {comp, {(WORD_W-COMP_W){1'b0}}};
	assign aligned     = top_aligned >> lz;

endmodule

`default_nettype wire

// File: hw/rtl/rppd_dither.sv
`default_nettype none

module rppd_dither (
	input  wire logic [rppd_pkg::LEVEL_W-1:0] level,
	input  wire logic [rppd_pkg::LEVEL_W-1:0] top_level,
	input  wire logic                         round_up,
	output logic      [rppd_pkg::LEVEL_W-1:0] level_out
);
	import rppd_pkg::*;

	// Step up one level when above threshold, saturate at the top level
	always_comb begin
		if (round_up && (level != top_level)) begin
			level_out = level + LEVEL_W'(1);
		end else begin
			level_out = level;
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/rgb_pixel_pack_ordered_dither_unit.sv
`default_nettype none

// RGB pixel packer with a 4x4 ordered-dither 3-3-2 mode. Each input transaction
// carries one pixel (pos_x, pos_y, red, green, blue) and yields exactly one
// output transaction holding a 32-bit frame-buffer word. In truecolor mode each
// component is aligned to the top bit of its channel mask, masked and ORed in;
// in pseudocolor mode red and green are dithered to three bits and blue to two,
// using the Bayer threshold at row pos_x mod 4 and column pos_y mod 4, and
// packed RRRGGGBB in bits 7..0. The datapath is a three-stage pipeline (mask
// leading-zero count and threshold compare, shift and dither, mask and pack),
// so a pixel is accepted every clock while the output is not stalled; its word
// passes the stage 1, 2 and 3 registers and is offered from stage 3. Write the
// configuration registers (index 0 colour mode, 1 red mask, 2 green mask,
// 3 blue mask) only while the pipeline is empty; the configuration port is
// always ready.
module rgb_pixel_pack_ordered_dither_unit (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// Configuration writes
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [rppd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [rppd_pkg::WORD_W-1:0]      cfg_data,
	// Pixel input
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	// pos_x[11:0], pos_y[23:12], red[31:24], green[39:32], blue[47:40]
	input  wire logic [rppd_pkg::IN_DATA_W-1:0]   s_tdata,
	// Packed pixel output
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// pixel_word[31:0]
	output logic      [rppd_pkg::WORD_W-1:0]      m_tdata
);
	import rppd_pkg::*;

	// Configuration registers
	logic              color_mode_q;
	logic [WORD_W-1:0] red_mask_q;
	logic [WORD_W-1:0] green_mask_q;
	logic [WORD_W-1:0] blue_mask_q;

	// Unpacked input fields
	logic [COORD_W-1:0] in_pos_x;
	logic [COORD_W-1:0] in_pos_y;
	logic [COMP_W-1:0]  in_red;
	logic [COMP_W-1:0]  in_green;
	logic [COMP_W-1:0]  in_blue;
	logic [THR_W-1:0]   in_thr;
	round_up_t          in_up;

	// Stage controls
	logic vld_s1, vld_s2, vld_s3;
	logic ready_s1, ready_s2, ready_s3;

	// Stage 1 payload
	logic [COMP_W-1:0]  red_s1, green_s1, blue_s1;
	logic [SHIFT_W-1:0] lz_red_s1, lz_green_s1, lz_blue_s1;
	round_up_t          up_s1;

	// Stage 2 payload
	logic [WORD_W-1:0]  al_red_s2, al_green_s2, al_blue_s2;
	logic [LEVEL_W-1:0] dq_red_s2, dq_green_s2, dq_blue_s2;

	// Stage 3 payload
	logic [WORD_W-1:0]  pix_s3;

	// Stage 2 combinational results
	logic [WORD_W-1:0]  al_red, al_green, al_blue;
	logic [LEVEL_W-1:0] dq_red, dq_green, dq_blue;

	// Stage 3 combinational result
	logic [WORD_W-1:0]  pix_true;
	logic [WORD_W-1:0]  pix_pseudo;

	assign cfg_ready = 1'b1;

	// Take configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_mode_q <= MODE_TRUECOLOR;
			red_mask_q   <= RED_MASK_RST;
			green_mask_q <= GREEN_MASK_RST;
			blue_mask_q  <= BLUE_MASK_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_COLOR_MODE: color_mode_q <= cfg_data[0];
				CFG_RED_MASK:   red_mask_q   <= cfg_data;
				CFG_GREEN_MASK: green_mask_q <= cfg_data;
				CFG_BLUE_MASK:  blue_mask_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Advance a stage when its successor is empty or moving on
	assign ready_s3 = !vld_s3 || m_tready;
	assign ready_s2 = !vld_s2 || ready_s3;
	assign ready_s1 = !vld_s1 || ready_s2;
	assign s_tready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (ready_s1) vld_s1 <= s_tvalid;
			if (ready_s2) vld_s2 <= vld_s1;
			if (ready_s3) vld_s3 <= vld_s2;
		end
	end

	// Stage 1: unpack, threshold compare, mask leading zeros
	assign in_pos_x = s_tdata[11:0];
	assign in_pos_y = s_tdata[23:12];
	assign in_red   = s_tdata[31:24];
	assign in_green = s_tdata[39:32];
	assign in_blue  = s_tdata[47:40];

	assign in_thr      = bayer_thr(in_pos_x[1:0], in_pos_y[1:0]);
	assign in_up.red   = in_red[4:0] > in_thr;
	assign in_up.green = in_green[4:0] > in_thr;
	assign in_up.blue  = in_blue[5:0] > {in_thr, 1'b0};

	always_ff @(posedge clk) begin
		if (ready_s1) begin
			red_s1      <= in_red;
			green_s1    <= in_green;
			blue_s1     <= in_blue;
			lz_red_s1   <= lead_zeros(red_mask_q);
			lz_green_s1 <= lead_zeros(green_mask_q);
			lz_blue_s1  <= lead_zeros(blue_mask_q);
			up_s1       <= in_up;
		end
	end

	// Stage 2: align to masks and dither
	rppd_align u_align_red (
		.comp    (red_s1),
		.lz      (lz_red_s1),
		.aligned (al_red)
	);

	rppd_align u_align_green (
		.comp    (green_s1),
		.lz      (lz_green_s1),
		.aligned (al_green)
	);

	rppd_align u_align_blue (
		.comp    (blue_s1),
		.lz      (lz_blue_s1),
		.aligned (al_blue)
	);

	rppd_dither u_dither_red (
		.level     (red_s1[7:5]),
		.top_level (TOP_LEVEL_3B),
		.round_up  (up_s1.red),
		.level_out (dq_red)
	);

	rppd_dither u_dither_green (
		.level     (green_s1[7:5]),
		.top_level (TOP_LEVEL_3B),
		.round_up  (up_s1.green),
		.level_out (dq_green)
	);

	rppd_dither u_dither_blue (
		.level     ({1'b0, blue_s1[7:6]}),
		.top_level (TOP_LEVEL_2B),
		.round_up  (up_s1.blue),
		.level_out (dq_blue)
	);

	always_ff @(posedge clk) begin
		if (ready_s2) begin
			al_red_s2   <= al_red;
			al_green_s2 <= al_green;
			al_blue_s2  <= al_blue;
			dq_red_s2   <= dq_red;
			dq_green_s2 <= dq_green;
			dq_blue_s2  <= dq_blue;
		end
	end

	// Stage 3: mask and merge, or pack RRRGGGBB
	assign pix_true   = (al_red_s2 & red_mask_q) | (al_green_s2 & green_mask_q) |
		(al_blue_s2 & blue_mask_q);
	assign pix_pseudo = {{(WORD_W-8){1'b0}}, dq_red_s2, dq_green_s2, dq_blue_s2[1:0]};

	always_ff @(posedge clk) begin
		if (ready_s3) begin
			pix_s3 <= (color_mode_q == MODE_PSEUDO) ? pix_pseudo : pix_true;
		end
	end

	assign m_tvalid = vld_s3;
	assign m_tdata  = pix_s3;

`include "assert_macros.svh"

	`ASSERT_PROP(a_full_when_blocked, !s_tready |-> (vld_s1 && vld_s2 && vld_s3), "input blocked with a free stage")
	`ASSERT_PROP(a_accept_fills_s1, (s_tvalid && s_tready) |=> vld_s1, "accepted transaction lost at stage 1")
	`ASSERT_PROP(a_s2_holds, (vld_s2 && !ready_s2) |=> (vld_s2 && $stable(al_red_s2) && $stable(dq_red_s2)), "stage 2 changed while stalled")
	`ASSERT_PROP(a_pseudo_high_zero, (vld_s3 && (color_mode_q == MODE_PSEUDO)) |-> (pix_s3[31:8] == 24'h0), "pseudocolour word has upper bits set")
	`ASSERT_NEVER(a_blue_over_top, vld_s2 && (dq_blue_s2 > TOP_LEVEL_2B), "blue level beyond two bits")

endmodule

`default_nettype wire
